// ===== src/ptpstc_pkg.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter: shared definitions
// Field widths, command and register codes, reset values and the request,
// result and configuration records used across the block.
// ----------------------------------------------------------------------------
package ptpstc_pkg;

	localparam int SEC_W   = 32;
	localparam int SUB_W   = 31;
	localparam int FRAC_W  = 8;
	localparam int INC_W   = 8;
	localparam int ACC_W   = 32;
	localparam int CMD_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// commands
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INIT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADJUST = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ADDEND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_NS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INC_FRAC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL  = 3'd4;

	// register reset values
	localparam logic [ACC_W-1:0]  ADDEND_RST   = 32'hF0BB_241D;
	localparam logic [INC_W-1:0]  INC_NS_RST   = 8'd1;
	localparam logic [FRAC_W-1:0] INC_FRAC_RST = 8'h6B;

	// sub-second rollover points, one bit wider than the count
	localparam logic [SUB_W:0] DIGITAL_LIMIT = 32'd1_000_000_000;
	localparam logic [SUB_W:0] BINARY_LIMIT  = 32'h8000_0000;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [SEC_W-1:0] offset_seconds;
		logic [SUB_W-1:0] offset_subseconds;
		logic             subtract;
	} req_t;

	typedef struct packed {
		logic [SEC_W-1:0] time_seconds;
		logic [SUB_W-1:0] time_subseconds;
		logic             second_rolled;
		logic             bad_operand;
	} rsp_t;

	typedef struct packed {
		logic [ACC_W-1:0]  addend;
		logic [INC_W-1:0]  increment_ns;
		logic [FRAC_W-1:0] increment_frac;
		logic              fine_mode;
		logic              digital_rollover;
	} cfg_t;

endpackage

// ===== src/ptpstc_if.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter: channel interfaces
// Request, result and configuration-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface ptpstc_req_if import ptpstc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [SEC_W-1:0] offset_seconds;
	logic [SUB_W-1:0] offset_subseconds;
	logic             subtract;

	modport source (output valid, command, offset_seconds, offset_subseconds, subtract,
		input ready);
	modport sink (input valid, command, offset_seconds, offset_subseconds, subtract,
		output ready);
endinterface

interface ptpstc_rsp_if import ptpstc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] time_seconds;
	logic [SUB_W-1:0] time_subseconds;
	logic             second_rolled;
	logic             bad_operand;

	modport source (output valid, time_seconds, time_subseconds, second_rolled,
		bad_operand, input ready);
	modport sink (input valid, time_seconds, time_subseconds, second_rolled,
		bad_operand, output ready);
endinterface

interface ptpstc_cfg_if import ptpstc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ptpstc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter: configuration registers
// Holds addend, increment and mode settings; writes to unknown indexes drop.
// ----------------------------------------------------------------------------
module ptpstc_cfg_regs import ptpstc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addend           <= ADDEND_RST;
			cfg_q.increment_ns     <= INC_NS_RST;
			cfg_q.increment_frac   <= INC_FRAC_RST;
			cfg_q.fine_mode        <= 1'b1;
			cfg_q.digital_rollover <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ADDEND:   cfg_q.addend           <= wr_data[ACC_W-1:0];
				CFG_INC_NS:   cfg_q.increment_ns     <= wr_data[INC_W-1:0];
				CFG_INC_FRAC: cfg_q.increment_frac   <= wr_data[FRAC_W-1:0];
				CFG_FINE:     cfg_q.fine_mode        <= wr_data[0];
				CFG_DIGITAL:  cfg_q.digital_rollover <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/ptpstc_time_unit.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter: time state and update logic
// Holds the time and accumulator; computes one request's effect combinationally.
// ----------------------------------------------------------------------------
module ptpstc_time_unit import ptpstc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic upd_en,
	input  req_t req,
	input  cfg_t cfg,
	output rsp_t rsp
);

	logic [SEC_W-1:0]  sec_q;
	logic [SUB_W-1:0]  sub_q;
	logic [FRAC_W-1:0] frac_q;
	logic [ACC_W-1:0]  acc_q;

	logic [SEC_W-1:0]  sec_n;
	logic [SUB_W-1:0]  sub_n;
	logic [FRAC_W-1:0] frac_n;
	logic [ACC_W-1:0]  acc_n;

	logic [SUB_W:0]    limit;
	logic [ACC_W:0]    acc_sum;
	logic              inc_fire;
	logic [FRAC_W:0]   frac_sum;
	logic [SUB_W:0]    tick_sum;
	logic              tick_roll;
	logic [SUB_W:0]    tick_wrap;
	logic [SUB_W:0]    offs;
	logic              bad;
	logic [SUB_W:0]    add_sum;
	logic              add_carry;
	logic [SUB_W:0]    add_wrap;
	logic              borrow;
	logic [SUB_W:0]    sub_diff;
	logic              rolled;

	assign limit = cfg.digital_rollover ? DIGITAL_LIMIT : BINARY_LIMIT;

	// tick path
	assign acc_sum   = {1'b0, acc_q} + {1'b0, cfg.addend};
	assign inc_fire  = !cfg.fine_mode || acc_sum[ACC_W];
	assign frac_sum  = {1'b0, frac_q} + {1'b0, cfg.increment_frac};
	assign tick_sum  = {1'b0, sub_q} + (SUB_W+1)'(cfg.increment_ns)
		+ (SUB_W+1)'(frac_sum[FRAC_W]);
	assign tick_roll = tick_sum >= limit;
	assign tick_wrap = tick_sum - limit;

	// adjust path
	assign offs      = {1'b0, req.offset_subseconds};
	assign bad       = offs >= limit;
	assign add_sum   = {1'b0, sub_q} + offs;
	assign add_carry = add_sum >= limit;
	assign add_wrap  = add_carry ? add_sum - limit : add_sum;
	assign borrow    = sub_q < req.offset_subseconds;
	assign sub_diff  = borrow ? {1'b0, sub_q} + limit - offs : {1'b0, sub_q} - offs;

	always_comb begin
		sec_n  = sec_q;
		sub_n  = sub_q;
		frac_n = frac_q;
		acc_n  = acc_q;
		rolled = 1'b0;
		unique case (req.command)
			CMD_TICK: begin
				if (cfg.fine_mode) begin
					acc_n = acc_sum[ACC_W-1:0];
				end
				if (inc_fire) begin
					frac_n = frac_sum[FRAC_W-1:0];
					rolled = tick_roll;
					if (tick_roll) begin
						sub_n = tick_wrap[SUB_W-1:0];
						sec_n = sec_q + SEC_W'(1);
					end else begin
						sub_n = tick_sum[SUB_W-1:0];
					end
				end
			end
			CMD_INIT: begin
				if (!bad) begin
					sec_n  = req.offset_seconds;
					sub_n  = req.offset_subseconds;
					frac_n = '0;
				end
			end
			CMD_ADJUST: begin
				if (!bad) begin
					if (req.subtract) begin
						sub_n = sub_diff[SUB_W-1:0];
						sec_n = sec_q - req.offset_seconds - SEC_W'(borrow);
					end else begin
						sub_n = add_wrap[SUB_W-1:0];
						sec_n = sec_q + req.offset_seconds + SEC_W'(add_carry);
					end
				end
			end
			CMD_READ: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			sub_q  <= '0;
			frac_q <= '0;
			acc_q  <= '0;
		end else if (upd_en) begin
			sec_q  <= sec_n;
			sub_q  <= sub_n;
			frac_q <= frac_n;
			acc_q  <= acc_n;
		end
	end

	assign rsp.time_seconds    = sec_n;
	assign rsp.time_subseconds = sub_n;
	assign rsp.second_rolled   = rolled;
	assign rsp.bad_operand     = bad && (req.command == CMD_INIT || req.command == CMD_ADJUST);

endmodule

// ===== src/ptp_system_time_counter_core.sv =====
// Flow: an accepted request waits in the request register until the result
//   register is free; its outcome then loads there and leaves with ready high.
// Throughput: 1 request per cycle while the result side keeps ready high; the
//   time state is read and rewritten as the request advances, so back-to-back
//   ticks each see the previous result.
// Reset (arst_n low, asynchronous): time, fraction and accumulator clear to
//   zero, configuration returns to its defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// PTP system-time counter core
// Seconds/sub-second system time with fine frequency correction, offset
// adjust, load and read, behind a request register and a result register.
// ----------------------------------------------------------------------------
module ptp_system_time_counter_core import ptpstc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ptpstc_req_if.sink         req,
	ptpstc_rsp_if.source       rsp,
	ptpstc_cfg_if.sink         cfg
);

	// Request register: holds one accepted request until the result register
	// can take its outcome.
	req_t req_s1;
	logic valid_s1;

	// Result register.
	rsp_t rsp_s2;
	logic valid_s2;

	cfg_t cfg_cur;
	rsp_t rsp_next;
	logic advance;

	// The configuration port never stalls.
	assign cfg.ready = 1'b1;

	ptpstc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_cur)
	);

	// Advance the request stage when the result register is empty or its
	// contents are being taken this cycle; the time state updates only then.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	ptpstc_time_unit u_time (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (advance),
		.req    (req_s1),
		.cfg    (cfg_cur),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Capture the request payload whenever the stage is free to load and a request is valid.
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.command           <= req.command;
			req_s1.offset_seconds    <= req.offset_seconds;
			req_s1.offset_subseconds <= req.offset_subseconds;
			req_s1.subtract          <= req.subtract;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp.valid           = valid_s2;
	assign rsp.time_seconds    = rsp_s2.time_seconds;
	assign rsp.time_subseconds = rsp_s2.time_subseconds;
	assign rsp.second_rolled   = rsp_s2.second_rolled;
	assign rsp.bad_operand     = rsp_s2.bad_operand;

`ifndef SYNTHESIS
	// A rollover only comes from a tick, a bad operand only from load/adjust.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(rsp_s2.second_rolled && rsp_s2.bad_operand))
		else $error("rollover and bad operand flagged together");

	// A request that cannot advance stays in the request register.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("request stage dropped a stalled request");

	// Every advance leaves a result in the result register.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced request produced no result");
`endif

endmodule

// ===== bench/ptpstc_time_checker.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter: result checker
// Watches the request, result and configuration channels, keeps its own copy
// of the system time and settings, and compares every result in order.
// ----------------------------------------------------------------------------
module ptpstc_time_checker import ptpstc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	ptpstc_req_if req,
	ptpstc_rsp_if rsp,
	ptpstc_cfg_if cfg,
	output int    pending,
	output int    mismatches,
	output int    checked_count,
	output int    rolled_count,
	output int    rejected_count
);

	cfg_t              settings;
	logic [SEC_W-1:0]  sec_count;
	logic [SUB_W-1:0]  sub_count;
	logic [FRAC_W-1:0] frac_count;
	logic [ACC_W-1:0]  freq_acc;
	rsp_t              expected_times[$];

	// Advance the time by one request and return the time it leaves behind.
	function automatic rsp_t apply_request(req_t r);
		rsp_t             res;
		logic [SUB_W:0]   limit;
		logic [ACC_W:0]   acc_sum;
		logic [FRAC_W:0]  frac_sum;
		logic [SUB_W:0]   sub_sum;
		logic             fire;
		limit = settings.digital_rollover ? DIGITAL_LIMIT : BINARY_LIMIT;
		res = '0;
		case (r.command)
		CMD_TICK: begin
			fire = 1'b1;
			if (settings.fine_mode) begin
				acc_sum = {1'b0, freq_acc} + {1'b0, settings.addend};
				fire = acc_sum[ACC_W];
				freq_acc = acc_sum[ACC_W-1:0];
			end
			if (fire) begin
				frac_sum = {1'b0, frac_count} + {1'b0, settings.increment_frac};
				frac_count = frac_sum[FRAC_W-1:0];
				sub_sum = {1'b0, sub_count} + (SUB_W+1)'(settings.increment_ns)
					+ (SUB_W+1)'(frac_sum[FRAC_W]);
				if (sub_sum >= limit) begin
					sub_sum = sub_sum - limit;
					sec_count = sec_count + SEC_W'(1);
					res.second_rolled = 1'b1;
				end
				sub_count = sub_sum[SUB_W-1:0];
			end
		end
		CMD_INIT, CMD_ADJUST: begin
			if ({1'b0, r.offset_subseconds} >= limit) begin
				res.bad_operand = 1'b1;
			end else if (r.command == CMD_INIT) begin
				sec_count = r.offset_seconds;
				sub_count = r.offset_subseconds;
				frac_count = '0;
			end else if (!r.subtract) begin
				sub_sum = {1'b0, sub_count} + {1'b0, r.offset_subseconds};
				if (sub_sum >= limit) begin
					sub_sum = sub_sum - limit;
					sec_count = sec_count + r.offset_seconds + SEC_W'(1);
				end else begin
					sec_count = sec_count + r.offset_seconds;
				end
				sub_count = sub_sum[SUB_W-1:0];
			end else begin
				if (sub_count < r.offset_subseconds) begin
					sub_sum = {1'b0, sub_count} + limit - {1'b0, r.offset_subseconds};
					sec_count = sec_count - r.offset_seconds - SEC_W'(1);
				end else begin
					sub_sum = {1'b0, sub_count} - {1'b0, r.offset_subseconds};
					sec_count = sec_count - r.offset_seconds;
				end
				sub_count = sub_sum[SUB_W-1:0];
			end
		end
		default: begin
		end
		endcase
		res.time_seconds = sec_count;
		res.time_subseconds = sub_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			settings.addend = ADDEND_RST;
			settings.increment_ns = INC_NS_RST;
			settings.increment_frac = INC_FRAC_RST;
			settings.fine_mode = 1'b1;
			settings.digital_rollover = 1'b1;
			sec_count = '0;
			sub_count = '0;
			frac_count = '0;
			freq_acc = '0;
			expected_times.delete();
			pending = 0;
			mismatches = 0;
			checked_count = 0;
			rolled_count = 0;
			rejected_count = 0;
		end else begin
			// results first: a result never belongs to a request taken on this edge
			if (rsp.valid && rsp.ready) begin
				got = rsp_t'{rsp.time_seconds, rsp.time_subseconds, rsp.second_rolled,
					rsp.bad_operand};
				if (expected_times.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, got);
					mismatches++;
				end else begin
					want = expected_times.pop_front();
					checked_count++;
					if (want.second_rolled)
						rolled_count++;
					if (want.bad_operand)
						rejected_count++;
					if (got.time_seconds !== want.time_seconds) begin
						$display("%0t: time_seconds expected %h actual %h", $time,
							want.time_seconds, got.time_seconds);
						mismatches++;
					end
					if (got.time_subseconds !== want.time_subseconds) begin
						$display("%0t: time_subseconds expected %h actual %h", $time,
							want.time_subseconds, got.time_subseconds);
						mismatches++;
					end
					if (got.second_rolled !== want.second_rolled) begin
						$display("%0t: second_rolled expected %b actual %b", $time,
							want.second_rolled, got.second_rolled);
						mismatches++;
					end
					if (got.bad_operand !== want.bad_operand) begin
						$display("%0t: bad_operand expected %b actual %b", $time,
							want.bad_operand, got.bad_operand);
						mismatches++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_ADDEND:   settings.addend = cfg.data[ACC_W-1:0];
				CFG_INC_NS:   settings.increment_ns = cfg.data[INC_W-1:0];
				CFG_INC_FRAC: settings.increment_frac = cfg.data[FRAC_W-1:0];
				CFG_FINE:     settings.fine_mode = cfg.data[0];
				CFG_DIGITAL:  settings.digital_rollover = cfg.data[0];
				default: begin
				end
				endcase
			end
			if (req.valid && req.ready)
				expected_times.push_back(apply_request(req_t'{req.command, req.offset_seconds,
					req.offset_subseconds, req.subtract}));
			pending = expected_times.size();
		end
	end

endmodule

// ===== bench/ptp_system_time_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// PTP system-time counter core: testbench
// Drives directed and random time requests through several register settings
// with random sender gaps and result stalls; a checker beside the block
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module ptp_system_time_counter_core_tb;
	import ptpstc_pkg::*;

	// result pipeline is two deep; let it settle after the last result
	localparam int DRAIN_CYCLES = 8;
	// slowest run: ~1000 requests, each behind the longest result stall and sender gap
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 140;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_MOSTLY} ready_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	int          cycle_count = 0;
	int          burst_left;
	logic        steady;
	logic        digital_mode;
	int          pending;
	int          mismatches;
	int          checked_count;
	int          rolled_count;
	int          rejected_count;
	ready_mode_e ready_mode;
	logic [31:0] ready_pattern;
	int          ready_hold = 0;

	ptpstc_req_if req_bus ();
	ptpstc_rsp_if rsp_bus ();
	ptpstc_cfg_if cfg_bus ();

	ptp_system_time_counter_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	ptpstc_time_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_bus),
		.rsp            (rsp_bus),
		.cfg            (cfg_bus),
		.pending        (pending),
		.mismatches     (mismatches),
		.checked_count  (checked_count),
		.rolled_count   (rolled_count),
		.rejected_count (rejected_count)
	);

	always #5 clk = ~clk;

	// Abort a hung run: a result that never comes ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ptp_system_time_counter_core_tb: FAIL");
			$finish;
		end
	end

	// Stall the result side on a pattern of its own: when its hold count runs out,
	// pick a new mode: always ready, coin flips, a rotating bit mask or mostly ready.
	always @(negedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = ready_mode_e'($urandom_range(0, 3));
			ready_pattern = $urandom | 32'h1;
			ready_hold = $urandom_range(20, 120);
		end
		ready_hold--;
		case (ready_mode)
		READY_ALWAYS: rsp_bus.ready = 1'b1;
		READY_COIN:   rsp_bus.ready = 1'($urandom_range(0, 1));
		READY_PATTERN: begin
			rsp_bus.ready = ready_pattern[0];
			ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
		end
		default:      rsp_bus.ready = ($urandom_range(0, 7) != 0);
		endcase
	end

	// Present one request and hold it until the block takes it. Bursts of
	// random length are separated by random gaps; in steady stretches the gaps
	// vanish. The request stays valid after acceptance until the next call or
	// a drain lowers it, so valid never drops and rises in one step.
	task automatic send_request(input logic [CMD_W-1:0] command,
		input logic [SEC_W-1:0] secs, input logic [SUB_W-1:0] subs, input logic subtract);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = (steady || $urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				req_bus.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_bus.command = command;
		req_bus.offset_seconds = secs;
		req_bus.offset_subseconds = subs;
		req_bus.subtract = subtract;
		req_bus.valid = 1'b1;
		do @(posedge clk); while (!req_bus.ready);
	endtask

	// Drop the request line and wait until every expected result is in,
	// then let the pipeline settle.
	task automatic drain_results();
		@(negedge clk);
		req_bus.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write one register; call only with the block idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data = value;
		do @(posedge clk); while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
		if (idx == CFG_DIGITAL)
			digital_mode = value[0];
	endtask

	// Random request: mostly ticks, with loads and adjusts that often land the
	// sub-seconds near the rollover point so that rollovers and carries occur.
	task automatic send_random_request();
		logic [CMD_W-1:0] command;
		logic [SEC_W-1:0] secs;
		logic [SUB_W-1:0] subs;
		logic [SUB_W:0]   limit;
		int               pick;
		limit = digital_mode ? DIGITAL_LIMIT : BINARY_LIMIT;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			command = CMD_TICK;
		else if (pick < 70)
			command = CMD_INIT;
		else if (pick < 90)
			command = CMD_ADJUST;
		else
			command = CMD_READ;
		secs = $urandom;
		case ($urandom_range(0, 15))
		0:       secs = '1;
		1:       secs = '0;
		default: begin
		end
		endcase
		case ($urandom_range(0, 5))
		// any 31-bit value: out of range about half the time in digital mode
		0:       subs = SUB_W'($urandom);
		1:       subs = SUB_W'(limit - $urandom_range(1, 300));
		2:       subs = SUB_W'($urandom_range(0, 600));
		default: subs = SUB_W'($urandom_range(0, limit - 1));
		endcase
		send_request(command, secs, subs, 1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		logic [ACC_W-1:0]  addend_v;
		logic [INC_W-1:0]  inc_ns_v;
		logic [FRAC_W-1:0] inc_frac_v;
		logic              fine_v;
		logic              digital_v;
		int                phase;
		int                n;

		// hold every input at a known value and reset once
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.command = CMD_TICK;
		req_bus.offset_seconds = '0;
		req_bus.offset_subseconds = '0;
		req_bus.subtract = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_ADDEND;
		cfg_bus.data = '0;
		rsp_bus.ready = 1'b0;
		burst_left = 0;
		steady = 1'b0;
		digital_mode = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under reset settings (fine mode, digital rollover).
		send_request(CMD_READ, '0, '0, 1'b0);
		// tick and read ignore the offset fields
		send_request(CMD_TICK, '1, '1, 1'b1);
		// load the last second before seconds wrap; ticks roll sub-seconds over
		send_request(CMD_INIT, '1, 31'd999_999_998, 1'b1);
		repeat (5) send_request(CMD_TICK, '0, '0, 1'b0);
		// out-of-range sub-seconds: request rejected, time unchanged
		send_request(CMD_INIT, 32'd7, 31'd1_000_000_000, 1'b0);
		send_request(CMD_INIT, 32'd7, '1, 1'b0);
		send_request(CMD_ADJUST, 32'd7, 31'd1_000_000_000, 1'b1);
		// adjust with carry, then with borrow and seconds wrap
		send_request(CMD_INIT, 32'd10, 31'd999_999_990, 1'b0);
		send_request(CMD_ADJUST, 32'd5, 31'd20, 1'b0);
		send_request(CMD_ADJUST, 32'd20, 31'd999_999_999, 1'b1);
		send_request(CMD_ADJUST, 32'd1, 31'd0, 1'b1);
		send_request(CMD_ADJUST, 32'd0, 31'd0, 1'b0);
		send_request(CMD_READ, $urandom, SUB_W'($urandom), 1'b1);
		// coarse mode with binary rollover at 2^31
		drain_results();
		write_register(CFG_FINE, 32'd0);
		write_register(CFG_DIGITAL, 32'd0);
		send_request(CMD_INIT, '0, 31'h7FFF_FFFE, 1'b0);
		send_request(CMD_TICK, '0, '0, 1'b0);
		send_request(CMD_INIT, 32'd3, 31'h7FFF_FFF0, 1'b0);
		// switch to digital with sub-seconds past the new rollover point
		drain_results();
		write_register(CFG_DIGITAL, 32'd1);
		send_request(CMD_TICK, '0, '0, 1'b0);
		send_request(CMD_ADJUST, 32'd1, 31'd100, 1'b0);
		send_request(CMD_ADJUST, 32'd1, 31'd999_999_999, 1'b1);
		send_request(CMD_READ, '0, '0, 1'b0);

		// Random part: one register setting per phase, extremes among them.
		for (phase = 0; phase < PHASES; phase++) begin
			drain_results();
			addend_v = $urandom;
			inc_ns_v = INC_W'($urandom_range(1, 40));
			inc_frac_v = FRAC_W'($urandom);
			fine_v = 1'($urandom_range(0, 1));
			digital_v = 1'($urandom_range(0, 1));
			case (phase)
			0: begin
				addend_v = '1;
				inc_ns_v = '1;
				inc_frac_v = '1;
				fine_v = 1'b1;
				digital_v = 1'b1;
			end
			1: begin
				// time frozen on ticks: only loads and adjusts move it
				addend_v = '0;
				inc_ns_v = '0;
				inc_frac_v = '0;
				fine_v = 1'b0;
				digital_v = 1'b0;
			end
			2: begin
				fine_v = 1'b0;
				digital_v = 1'b1;
			end
			3: begin
				inc_ns_v = INC_W'($urandom);
				fine_v = 1'b1;
				digital_v = 1'b0;
			end
			4: begin
				addend_v = 32'h8000_0000;
				inc_frac_v = '0;
				fine_v = 1'b1;
				digital_v = 1'b1;
			end
			default: begin
			end
			endcase
			write_register(CFG_ADDEND, addend_v);
			write_register(CFG_INC_NS, {24'd0, inc_ns_v});
			write_register(CFG_INC_FRAC, {24'd0, inc_frac_v});
			write_register(CFG_FINE, {31'd0, fine_v});
			write_register(CFG_DIGITAL, {31'd0, digital_v});
			steady = ($urandom_range(0, 2) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// pause mid-phase until every result is back
				if ((phase == 2 && n == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
					drain_results();
				send_random_request();
			end
			// park sub-seconds high so the next rollover mode may start past its limit
			send_request(CMD_INIT, $urandom,
				digital_mode ? 31'd999_999_000 : 31'h7FFF_FF00, 1'b0);
		end

		drain_results();
		$display("Checked %0d results over %0d register settings", checked_count, PHASES + 3);
		$display("  with %0d second rollovers and %0d rejected operands", rolled_count,
			rejected_count);
		if (mismatches == 0)
			$display("ptp_system_time_counter_core_tb: PASS");
		else
			$display("ptp_system_time_counter_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/ptpstc_pkg.sv
src/ptpstc_if.sv
src/ptpstc_cfg_regs.sv
src/ptpstc_time_unit.sv
src/ptp_system_time_counter_core.sv
bench/ptpstc_time_checker.sv
bench/ptp_system_time_counter_core_tb.sv
